// ===== hw/rtl/frx_pkg.sv =====
// shared types and constants for the xor checked frame receiver
`timescale 1ns / 1ps

package frx_pkg;

  localparam int MAX_FRAME_DEF  = 64;
  localparam int OUT_MAX_DEF    = 40;
  localparam int FRAME_OVERHEAD = 6;
  localparam int MIN_LEN        = 2;
  localparam int DATA_OFFSET    = 2;

  localparam int CFG_IDX_W = 8;
  localparam int CNT_OUT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hEF;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hAA;

  typedef struct packed {
    logic [7:0]           msg_type;
    logic [7:0]           resp_cmd;
    logic [7:0]           error_code;
    logic [CNT_OUT_W-1:0] data_count;
    logic                 bank;
  } frx_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } frx_fifo_stat_t;

endpackage

// ===== hw/rtl/frx_payload_buf.sv =====
// two-bank payload memory with registered read
`timescale 1ns / 1ps

module frx_payload_buf #(
  parameter int MAX_FRAME = frx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME - frx_pkg::FRAME_OVERHEAD)
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [AW:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        rd_en,
  input  logic [AW:0] rd_addr,
  output logic [7:0]  rd_data
);
  import frx_pkg::*;

  localparam int DEPTH = 2 << AW;

  logic [7:0] mem_r [0:DEPTH-1];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/frx_desc_fifo.sv =====
// two-entry queue of accepted frame descriptors
`timescale 1ns / 1ps

module frx_desc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  frx_pkg::frx_desc_t      push_desc,
  input  logic                    pop,
  output frx_pkg::frx_desc_t      head,
  output frx_pkg::frx_fifo_stat_t stat
);
  import frx_pkg::*;

  frx_desc_t  entry_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        entry_r[wr_ptr_r] <= push_desc;
        wr_ptr_r          <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  assign head       = entry_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

// ===== hw/rtl/frx_front.sv =====
// frame parser: header hunt, length check, payload store and xor check
`timescale 1ns / 1ps

module frx_front #(
  parameter int MAX_FRAME = frx_pkg::MAX_FRAME_DEF,
  parameter int OUT_MAX   = frx_pkg::OUT_MAX_DEF,
  localparam int AW = $clog2(MAX_FRAME - frx_pkg::FRAME_OVERHEAD)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  frx_pkg::frx_fifo_stat_t       fifo_stat,
  output logic                          push,
  output frx_pkg::frx_desc_t            push_desc,
  output logic                          wr_en,
  output logic [AW:0]                   wr_addr,
  output logic [7:0]                    wr_data
);
  import frx_pkg::*;

  localparam int STORE_DEPTH = MAX_FRAME - FRAME_OVERHEAD;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_HUNT1, ST_HUNT2, ST_TYPE, ST_LENHI, ST_LENLO, ST_PAYLOAD, ST_CHECK
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       len_hi_r, len_hi_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       parity_r, parity_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       err_r, err_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       hdr1_r;
  logic [7:0]       hdr2_r;

  logic             in_fire;
  logic [15:0]      full_len;
  logic [CNT_W-1:0] data_len;

  assign in_tready = !fifo_stat.full;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign full_len  = {len_hi_r, in_tdata};
  assign data_len  = len_r - CNT_W'(MIN_LEN);

  assign wr_en   = in_fire && (state_r == ST_PAYLOAD);
  assign wr_addr = {bank_r, AW'(cnt_r)};
  assign wr_data = in_tdata;

  always_comb begin
    state_nxt  = state_r;
    type_nxt   = type_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    parity_nxt = parity_r;
    cmd_nxt    = cmd_r;
    err_nxt    = err_r;
    bank_nxt   = bank_r;
    push       = 1'b0;

    push_desc.msg_type   = type_r;
    push_desc.resp_cmd   = cmd_r;
    push_desc.error_code = err_r;
    push_desc.bank       = bank_r;
    if (32'(data_len) > OUT_MAX) begin
      push_desc.data_count = CNT_OUT_W'(OUT_MAX);
    end else begin
      push_desc.data_count = CNT_OUT_W'(data_len);
    end

    if (in_fire) begin
      unique case (state_r)
        ST_HUNT2: begin
          state_nxt = (in_tdata == hdr2_r) ? ST_TYPE : ST_HUNT1;
        end
        ST_TYPE: begin
          type_nxt   = in_tdata;
          parity_nxt = in_tdata;
          state_nxt  = ST_LENHI;
        end
        ST_LENHI: begin
          len_hi_nxt = in_tdata;
          parity_nxt = parity_r ^ in_tdata;
          state_nxt  = ST_LENLO;
        end
        ST_LENLO: begin
          parity_nxt = parity_r ^ in_tdata;
          if (full_len < 16'(MIN_LEN) || full_len > 16'(STORE_DEPTH)) begin
            state_nxt = ST_HUNT1;
          end else begin
            len_nxt   = CNT_W'(full_len);
            cnt_nxt   = '0;
            state_nxt = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          cnt_nxt    = cnt_r + CNT_W'(1);
          parity_nxt = parity_r ^ in_tdata;
          if (cnt_r == CNT_W'(0)) begin
            cmd_nxt = in_tdata;
          end
          if (cnt_r == CNT_W'(1)) begin
            err_nxt = in_tdata;
          end
          if (cnt_r + CNT_W'(1) >= len_r) begin
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_nxt = ST_HUNT1;
          if (in_tdata == parity_r) begin
            push     = 1'b1;
            bank_nxt = ~bank_r;
          end
        end
        default: begin
          state_nxt = (in_tdata == hdr1_r) ? ST_HUNT2 : ST_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT1;
      type_r   <= '0;
      len_hi_r <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      parity_r <= '0;
      bank_r   <= 1'b0;
      hdr1_r   <= HEADER_FIRST_RST;
      hdr2_r   <= HEADER_SECOND_RST;
    end else begin
      state_r  <= state_nxt;
      type_r   <= type_nxt;
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      parity_r <= parity_nxt;
      bank_r   <= bank_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_HEADER_FIRST:  hdr1_r <= cfg_data;
          REG_HEADER_SECOND: hdr2_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    err_r <= err_nxt;
  end

endmodule

// ===== hw/rtl/frx_back.sv =====
// result sequencer: one beat per data byte of each queued frame, or a single beat for a frame without data
`timescale 1ns / 1ps

module frx_back #(
  parameter int MAX_FRAME = frx_pkg::MAX_FRAME_DEF,
  localparam int AW = $clog2(MAX_FRAME - frx_pkg::FRAME_OVERHEAD)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  frx_pkg::frx_desc_t      head,
  input  frx_pkg::frx_fifo_stat_t fifo_stat,
  output logic                    pop,
  output logic                    rd_en,
  output logic [AW:0]             rd_addr,
  input  logic [7:0]              rd_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [47:0]             out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);
  import frx_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SEND} state_t;

  state_t               state_r;
  logic [CNT_OUT_W-1:0] idx_r;
  logic [CNT_OUT_W-1:0] idx_nxt;
  logic [7:0]           data_r;
  logic                 has_data_r;
  logic                 last_r;
  logic                 out_fire;

  assign out_fire = (state_r == ST_SEND) && out_tready;
  assign pop      = out_fire && last_r;
  assign idx_nxt  = (state_r == ST_IDLE) ? '0 : idx_r + CNT_OUT_W'(1);
  assign rd_addr  = {head.bank, AW'(idx_nxt + CNT_OUT_W'(DATA_OFFSET))};
  assign rd_en    = ((state_r == ST_IDLE) && !fifo_stat.empty &&
                     (head.data_count != '0)) || (out_fire && !last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!fifo_stat.empty) begin
            idx_r <= '0;
            if (head.data_count == '0) begin
              data_r     <= '0;
              has_data_r <= 1'b0;
              last_r     <= 1'b1;
              state_r    <= ST_SEND;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          data_r     <= rd_data;
          has_data_r <= 1'b1;
          last_r     <= (idx_r + CNT_OUT_W'(1) == head.data_count);
          state_r    <= ST_SEND;
        end
        ST_SEND: begin
          if (out_tready) begin
            if (last_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_nxt;
              state_r <= ST_READ;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == ST_SEND);
  assign out_tdata  = {4'd0, data_r, idx_r[5:0], head.data_count[5:0],
                       head.error_code, head.resp_cmd, head.msg_type};
  assign out_tuser  = has_data_r;
  assign out_tlast  = last_r;

endmodule

// ===== hw/rtl/xor_checked_frame_receiver.sv =====
// top level of the xor checked frame receiver
`timescale 1ns / 1ps

// usage:
//   in_*  : one received serial byte per beat in in_tdata[7:0]
//   cfg_* : register writes (0 first sync byte, 1 second sync byte), always ready;
//           write only while the block is idle
//   out_* : one beat per delivered data byte of a frame that passed its xor
//           check, or a single beat with out_tuser low for a frame without data;
//           out_tlast marks the final beat of the frame
// delivery: after its check byte is accepted a frame is queued, then its first data
//   byte is read from memory and presented; a frame without data skips the
//   memory read; each further data beat takes a memory read, then present/accept
// throughput: the parser takes one byte per cycle while the two-entry frame
//   queue has room; in_tready drops when two checked frames await delivery,
//   since each one holds a bank of the payload memory
// reset: sync bytes return to 0xEF, 0xAA; the parser hunts for a header and
//   the queue is emptied
// a stalled out_tready holds the current beat and, once the queue fills,
//   stalls the input side too

module xor_checked_frame_receiver #(
  parameter int MAX_FRAME = frx_pkg::MAX_FRAME_DEF,
  parameter int OUT_MAX   = frx_pkg::OUT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // msg_type, resp_cmd, error_code, data_count, byte_index, data_byte, zero pad
  output logic [47:0]                   out_tdata,
  output logic                          out_tuser,  // has_data
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [frx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import frx_pkg::*;

  localparam int AW = $clog2(MAX_FRAME - FRAME_OVERHEAD);

  frx_fifo_stat_t fifo_stat;
  frx_desc_t      push_desc;
  frx_desc_t      head;
  logic           push;
  logic           pop;
  logic           wr_en;
  logic [AW:0]    wr_addr;
  logic [7:0]     wr_data;
  logic           rd_en;
  logic [AW:0]    rd_addr;
  logic [7:0]     rd_data;

  frx_front #(.MAX_FRAME(MAX_FRAME), .OUT_MAX(OUT_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_desc (push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  frx_payload_buf #(.MAX_FRAME(MAX_FRAME)) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frx_desc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  frx_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_stat.full)
    else $error("frame pushed into a full queue");

  a_out_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !fifo_stat.empty)
    else $error("result beat without a queued frame");

  a_empty_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("beat without data is not the last of its frame");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (out_tvalid && out_tready && out_tlast))
    else $error("queue popped outside the final beat");

endmodule

// ===== tb/xor_checked_frame_receiver_test.sv =====
// testbench for the xor checked frame receiver, beats checked against a parser model
`timescale 1ns / 1ps

module xor_checked_frame_receiver_test;
  import frx_pkg::*;

  localparam int STORE_DEPTH = MAX_FRAME_DEF - FRAME_OVERHEAD;
  localparam int IDLE_PCT    = 9;
  localparam int DRAIN_CYC   = 20;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, TAKE_TYPE, LEN_HIGH, LEN_LOW, TAKE_PAYLOAD, TAKE_CHECK
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] msg_type;
    logic [7:0] resp_cmd;
    logic [7:0] error_code;
    logic [5:0] data_count;
    logic [5:0] byte_index;
    logic [7:0] data_byte;
    logic       has_data;
    logic       last;
  } frame_beat_t;

  typedef logic [7:0] byte_q_t[$];

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_data   = '0;

  bit          gaps_on    = 1'b1;
  int          bytes_sent = 0;
  int          fail_count = 0;
  frame_beat_t expected_beats[$];

  logic [7:0]   hdr_first;
  logic [7:0]   hdr_second;
  parse_phase_t parse_phase;
  logic [7:0]   frm_type;
  logic [15:0]  frm_len;
  int           payload_cnt;
  logic [7:0]   frm_parity;
  logic [7:0]   payload_mem [STORE_DEPTH];

  xor_checked_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic void reset_parser();
    hdr_first   = HEADER_FIRST_RST;
    hdr_second  = HEADER_SECOND_RST;
    parse_phase = HUNT_FIRST;
    frm_type    = '0;
    frm_len     = '0;
    payload_cnt = 0;
    frm_parity  = '0;
  endfunction

  function automatic void emit_frame();
    int          n;
    int          i;
    frame_beat_t beat;
    n = int'(frm_len) - DATA_OFFSET;
    if (n > OUT_MAX_DEF) n = OUT_MAX_DEF;
    beat.msg_type   = frm_type;
    beat.resp_cmd   = payload_mem[0];
    beat.error_code = payload_mem[1];
    beat.data_count = n[5:0];
    if (n == 0) begin
      beat.byte_index = '0;
      beat.data_byte  = '0;
      beat.has_data   = 1'b0;
      beat.last       = 1'b1;
      expected_beats.push_back(beat);
    end else begin
      for (i = 0; i < n; i++) begin
        beat.byte_index = i[5:0];
        beat.data_byte  = (i + DATA_OFFSET < STORE_DEPTH) ? payload_mem[i + DATA_OFFSET] : '0;
        beat.has_data   = 1'b1;
        beat.last       = (i + 1 == n);
        expected_beats.push_back(beat);
      end
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    case (parse_phase)
      HUNT_SECOND: begin
        parse_phase = (b == hdr_second) ? TAKE_TYPE : HUNT_FIRST;
      end
      TAKE_TYPE: begin
        frm_type    = b;
        frm_parity  = b;
        parse_phase = LEN_HIGH;
      end
      LEN_HIGH: begin
        frm_len     = {b, 8'h00};
        frm_parity ^= b;
        parse_phase = LEN_LOW;
      end
      LEN_LOW: begin
        frm_len[7:0] = b;
        frm_parity  ^= b;
        if (frm_len < MIN_LEN || frm_len > STORE_DEPTH) begin
          parse_phase = HUNT_FIRST;
        end else begin
          payload_cnt = 0;
          parse_phase = TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        if (payload_cnt < STORE_DEPTH) payload_mem[payload_cnt] = b;
        payload_cnt++;
        frm_parity ^= b;
        if (payload_cnt >= frm_len) parse_phase = TAKE_CHECK;
      end
      TAKE_CHECK: begin
        parse_phase = HUNT_FIRST;
        if (b == frm_parity) emit_frame();
      end
      default: begin
        parse_phase = (b == hdr_first) ? HUNT_SECOND : HUNT_FIRST;
      end
    endcase
  endfunction

  function automatic string beat_text(input frame_beat_t t);
    return $sformatf("type %h cmd %h err %h count %0d index %0d data %h has %b last %b",
                     t.msg_type, t.resp_cmd, t.error_code, t.data_count, t.byte_index,
                     t.data_byte, t.has_data, t.last);
  endfunction

  always @(posedge clk) begin
    frame_beat_t seen;
    frame_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.msg_type   = out_tdata[7:0];
      seen.resp_cmd   = out_tdata[15:8];
      seen.error_code = out_tdata[23:16];
      seen.data_count = out_tdata[29:24];
      seen.byte_index = out_tdata[35:30];
      seen.data_byte  = out_tdata[43:36];
      seen.has_data   = out_tuser;
      seen.last       = out_tlast;
      if (expected_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected beat: %s", beat_text(seen));
      end else begin
        want = expected_beats.pop_front();
        if (seen.msg_type !== want.msg_type || seen.resp_cmd !== want.resp_cmd ||
            seen.error_code !== want.error_code || seen.data_count !== want.data_count ||
            seen.byte_index !== want.byte_index || seen.data_byte !== want.data_byte ||
            seen.has_data !== want.has_data || seen.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("beat mismatch at %0t", $realtime);
            $display("  expected %s", beat_text(want));
            $display("  actual   %s", beat_text(seen));
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_HEADER_FIRST) hdr_first = val;
    else if (idx == REG_HEADER_SECOND) hdr_second = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                            input byte_q_t body, input bit bad_check);
    logic [7:0] chk;
    chk = ftype ^ len[15:8] ^ len[7:0];
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(ftype);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len < MIN_LEN || len > STORE_DEPTH) return;
    foreach (body[i]) begin
      send_byte(body[i]);
      chk ^= body[i];
    end
    if (bad_check) chk ^= 8'($urandom_range(255, 1));
    send_byte(chk);
  endtask

  function automatic byte_q_t random_body(input int n);
    byte_q_t body;
    repeat (n) body.push_back(8'($urandom_range(255)));
    return body;
  endfunction

  task automatic send_random_frame();
    int          pick;
    int          len;
    logic [15:0] bad_len;
    logic [7:0]  filler;
    byte_q_t     none;
    // get the parser back to header hunting
    while (parse_phase != HUNT_FIRST) begin
      filler = 8'($urandom_range(255));
      if (filler != hdr_first) send_byte(filler);
    end
    pick = $urandom_range(99);
    if (pick < 5) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
    end else if (pick < 10) begin
      send_byte(hdr_first);
      send_byte(hdr_second ^ 8'($urandom_range(255, 1)));
    end else if (pick < 16) begin
      case ($urandom_range(3))
        0: bad_len = 16'(MIN_LEN - 1);
        1: bad_len = '0;
        2: bad_len = 16'($urandom_range(255, STORE_DEPTH + 1));
        default: bad_len = {8'($urandom_range(255, 1)), 8'($urandom_range(255))};
      endcase
      send_frame(8'($urandom_range(255)), bad_len, none, 1'b0);
    end else begin
      len = $urandom_range(99);
      if (len < 70) len = $urandom_range(10, MIN_LEN);
      else if (len < 85) len = $urandom_range(OUT_MAX_DEF + 1, 11);
      else len = $urandom_range(STORE_DEPTH, OUT_MAX_DEF + DATA_OFFSET);
      send_frame(8'($urandom_range(255)), 16'(len), random_body(len), pick < 26);
    end
  endtask

  task automatic test_default_headers();
    byte_q_t    body;
    byte_q_t    none;
    logic [7:0] chk;
    // command and error code only, no data, then a frame with one data byte
    body = '{8'h00, 8'hFF};
    send_frame(8'hFF, 16'd2, body, 1'b0);
    body = '{8'hFF, 8'h00, 8'hFF};
    send_frame(8'h00, 16'd3, body, 1'b0);
    // second sync byte mismatch; the slipped byte does not restart the hunt
    send_byte(hdr_first);
    send_byte(hdr_first);
    send_byte(hdr_second);
    chk = 8'h5A ^ 8'h00 ^ 8'h02 ^ 8'h12 ^ 8'h34;
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(chk);
    // length one past the store
    send_frame(8'h81, 16'(STORE_DEPTH + 1), none, 1'b0);
  endtask

  task automatic test_long_frames();
    gaps_on = 1'b0;
    send_frame(8'($urandom_range(255)), 16'(OUT_MAX_DEF + DATA_OFFSET),
               random_body(OUT_MAX_DEF + DATA_OFFSET), 1'b0);
    send_frame(8'($urandom_range(255)), 16'(OUT_MAX_DEF + DATA_OFFSET + 1),
               random_body(OUT_MAX_DEF + DATA_OFFSET + 1), 1'b0);
    send_frame(8'($urandom_range(255)), 16'(STORE_DEPTH), random_body(STORE_DEPTH), 1'b0);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_header_setting(input logic [7:0] h1, input logic [7:0] h2,
                                     input int n_bytes);
    int stop_at;
    wait_idle();
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_HEADER_SECOND, h2);
    // unmapped index, must leave both sync bytes alone
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_HEADER_SECOND + 1)),
              8'($urandom_range(255)));
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  initial begin
    reset_parser();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_default_headers();
    test_long_frames();
    test_header_setting(8'h00, 8'hFF, 30);
    test_header_setting(8'hFF, 8'h00, 30);
    test_header_setting(8'h5A, 8'h5A, 25);
    test_header_setting(8'($urandom_range(255)), 8'($urandom_range(255)), 25);
    test_header_setting(HEADER_FIRST_RST, HEADER_SECOND_RST, 20);
    wait_idle();
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
